/* src/scf_pkg.sv */
// Shared widths, register indexes and cell payload types for the sphere contact frame.
`timescale 1ns / 1ps

package scf_pkg;

    // Square root chain: a 66-bit radicand gives a 33-bit root, one bit per cell.
    localparam int ROOT_W = 33;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    // Divider chain: a 63-bit dividend gives a 31-bit quotient, one bit per cell.
    localparam int QUO_W  = 31;
    localparam int DEN_W  = 33;
    localparam int DVD_W  = QUO_W + 32;
    localparam int FRAC_W = 30;

    // Register indexes on the configuration port.
    localparam logic [0:0] REG_RADIUS_ONE = 1'b0;
    localparam logic [0:0] REG_RADIUS_TWO = 1'b1;

    localparam logic [30:0] RADIUS_RESET = 31'd65536;

    // Data handed from one square root cell to the next.
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } root_step_t;

    // Data handed from one divider cell to the next.
    typedef struct packed {
        logic [DEN_W-1:0] part;
        logic [QUO_W-1:0] rq;
        logic [DEN_W-1:0] den;
    } div_step_t;

endpackage

/* src/scf_root_cell.sv */
// One digit cell of the pipelined integer square root.
`timescale 1ns / 1ps

module scf_root_cell (
    input  logic                clk,
    input  logic                ena,
    input  scf_pkg::root_step_t step_in,
    output scf_pkg::root_step_t step_out
);

    logic [scf_pkg::REM_W+1:0] rem_ext;
    logic [scf_pkg::REM_W+1:0] trial;
    logic                      take;
    scf_pkg::root_step_t       step_next;
    scf_pkg::root_step_t       step_reg;

    // Bring down the next bit pair and try the trial subtraction.
    always_comb
    begin
        rem_ext = {step_in.rem, step_in.rad[scf_pkg::RAD_W-1 -: 2]};
        trial   = (scf_pkg::REM_W+2)'({step_in.root, 2'b01});
        take    = (rem_ext >= trial);
        step_next.rad  = step_in.rad << 2;
        step_next.rem  = take ? scf_pkg::REM_W'(rem_ext - trial) : scf_pkg::REM_W'(rem_ext);
        step_next.root = {step_in.root[scf_pkg::ROOT_W-2:0], take};
    end

    // Stage register of this cell.
    always_ff @(posedge clk)
    begin
        if (ena)
        begin
            step_reg <= step_next;
        end
    end

    assign step_out = step_reg;

endmodule

/* src/scf_root.sv */
// Row of square root cells giving the floor root of a 66-bit radicand.
`timescale 1ns / 1ps

module scf_root (
    input  logic                        clk,
    input  logic                        ena,
    input  logic [scf_pkg::RAD_W-1:0]   radicand,
    output logic [scf_pkg::ROOT_W-1:0]  root
);

    scf_pkg::root_step_t link [scf_pkg::ROOT_W+1];

    // The first cell starts with an empty remainder and root.
    always_comb
    begin
        link[0].rad  = radicand;
        link[0].rem  = '0;
        link[0].root = '0;
    end

    for (genvar g = 0; g < scf_pkg::ROOT_W; g++)
    begin : g_step
        scf_root_cell u_step (
            .clk      (clk),
            .ena      (ena),
            .step_in  (link[g]),
            .step_out (link[g+1])
        );
    end

    assign root = link[scf_pkg::ROOT_W].root;

endmodule

/* src/scf_div_cell.sv */
// One quotient bit cell of the pipelined restoring divider.
`timescale 1ns / 1ps

module scf_div_cell (
    input  logic               clk,
    input  logic               ena,
    input  scf_pkg::div_step_t step_in,
    output scf_pkg::div_step_t step_out
);

    logic [scf_pkg::DEN_W:0] trial;
    logic                    take;
    scf_pkg::div_step_t      step_next;
    scf_pkg::div_step_t      step_reg;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb
    begin
        trial = {step_in.part, step_in.rq[scf_pkg::QUO_W-1]};
        take  = (trial >= {1'b0, step_in.den});
        step_next.part = take ? scf_pkg::DEN_W'(trial - {1'b0, step_in.den})
                              : scf_pkg::DEN_W'(trial);
        step_next.rq   = {step_in.rq[scf_pkg::QUO_W-2:0], take};
        step_next.den  = step_in.den;
    end

    // Stage register of this cell.
    always_ff @(posedge clk)
    begin
        if (ena)
        begin
            step_reg <= step_next;
        end
    end

    assign step_out = step_reg;

endmodule

/* src/scf_div.sv */
// Row of divider cells giving a 31-bit quotient of a 63-bit dividend.
`timescale 1ns / 1ps

module scf_div (
    input  logic                       clk,
    input  logic                       ena,
    input  logic [scf_pkg::DVD_W-1:0]  dividend,
    input  logic [scf_pkg::DEN_W-1:0]  den,
    output logic [scf_pkg::QUO_W-1:0]  quo
);

    scf_pkg::div_step_t link [scf_pkg::QUO_W+1];

    // The upper dividend bits form the first partial remainder.
    always_comb
    begin
        link[0].part = scf_pkg::DEN_W'(dividend[scf_pkg::DVD_W-1:scf_pkg::QUO_W]);
        link[0].rq   = dividend[scf_pkg::QUO_W-1:0];
        link[0].den  = den;
    end

    for (genvar g = 0; g < scf_pkg::QUO_W; g++)
    begin : g_step
        scf_div_cell u_step (
            .clk      (clk),
            .ena      (ena),
            .step_in  (link[g]),
            .step_out (link[g+1])
        );
    end

    assign quo = link[scf_pkg::QUO_W].rq;

endmodule

/* src/sphere_contact_frame.sv */
// Top level: pipelined gap distance and contact frame for one sphere pair per cycle.
//
//   channel   direction  handshake                      payload
//   item      in         item_valid / item_stall        first_x..z, second_x..z
//   result    out        result_valid / result_stall    gap, normal, tangent_u, tangent_v, degenerate
//   config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A new item is taken every cycle while item_stall is low.
// The 73 stages are five front stages, a 33-cell square root row, a 31-cell divider row
// and four frame stages in series.
// Reset clears the valid pipeline and sets both radii to 1.0.
// While a result waits under result_stall the whole pipeline holds and item_stall is high.
// There is no clearing pass after reset.
`timescale 1ns / 1ps

module sphere_contact_frame (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [31:0] first_x,
    input  logic signed [31:0] first_y,
    input  logic signed [31:0] first_z,
    input  logic signed [31:0] second_x,
    input  logic signed [31:0] second_y,
    input  logic signed [31:0] second_z,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] gap,
    output logic signed [31:0] normal_x,
    output logic signed [31:0] normal_y,
    output logic signed [31:0] normal_z,
    output logic signed [31:0] tangent_u_x,
    output logic signed [31:0] tangent_u_y,
    output logic signed [31:0] tangent_u_z,
    output logic signed [31:0] tangent_v_x,
    output logic signed [31:0] tangent_v_y,
    output logic signed [31:0] tangent_v_z,
    output logic               degenerate,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int LAT    = 73;
    localparam int ST_DLY = 35;
    localparam int GP_DLY = 37;
    localparam int ZF_DLY = 70;
    localparam int SG_DLY = 31;
    localparam int NU_DLY = 4;

    logic              adv;
    logic [LAT:1]      vld_reg;
    logic [30:0]       radius_one_reg;
    logic [30:0]       radius_two_reg;

    logic signed [32:0] d_reg [3];
    logic [31:0]        dmag [3];
    logic [31:0]        mx;
    logic [30:0]        mxs;
    logic [30:0]        sm [3];
    logic [63:0]        dsq_reg [3];
    logic signed [31:0] s_reg [3];

    logic [65:0]        dsum_reg;
    logic signed [32:0] t_reg [3];
    logic signed [31:0] s3_reg [3];

    logic [30:0]        s3mag [3];
    logic [31:0]        t3mag [3];
    logic [61:0]        ssq_reg [3];
    logic [63:0]        tsq_reg [3];
    logic signed [31:0] s_pipe [ST_DLY][3];
    logic signed [32:0] t_pipe [ST_DLY][3];
    logic               zf_pipe [ZF_DLY];

    logic [63:0]        ssum_reg;
    logic [65:0]        tsum_reg;

    logic [scf_pkg::ROOT_W-1:0] dnorm;
    logic [scf_pkg::ROOT_W-1:0] snorm;
    logic [scf_pkg::ROOT_W-1:0] tnorm;
    logic signed [34:0]         gap_wide;
    logic signed [31:0]         gap_sat;
    logic signed [31:0]         gap_pipe [GP_DLY];

    logic [31:0]                snum [3];
    logic [31:0]                tnum [3];
    logic [scf_pkg::DVD_W-1:0]  n_dvd [3];
    logic [scf_pkg::DVD_W-1:0]  u_dvd [3];
    logic [scf_pkg::QUO_W-1:0]  n_quo [3];
    logic [scf_pkg::QUO_W-1:0]  u_quo [3];
    logic [5:0]                 sg_pipe [SG_DLY];

    logic signed [31:0] n_pipe [NU_DLY][3];
    logic signed [31:0] u_pipe [NU_DLY][3];
    logic signed [63:0] prod_reg [6];
    logic signed [64:0] cross_reg [3];
    logic [64:0]        cmag [3];
    logic [64:0]        crnd [3];
    logic signed [31:0] v_reg [3];

    // Pipeline advances unless a finished result is held at the output.
    assign adv        = !(vld_reg[LAT] && result_stall);
    assign item_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-1:1], item_valid};
        end
    end

    // Configuration registers.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_one_reg <= scf_pkg::RADIUS_RESET;
            radius_two_reg <= scf_pkg::RADIUS_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                scf_pkg::REG_RADIUS_ONE: radius_one_reg <= pwdata[30:0];
                scf_pkg::REG_RADIUS_TWO: radius_two_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            scf_pkg::REG_RADIUS_ONE: prdata = {1'b0, radius_one_reg};
            scf_pkg::REG_RADIUS_TWO: prdata = {1'b0, radius_two_reg};
            default:                 prdata = '0;
        endcase
    end

    // Stage 1: center difference.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg[0] <= {first_x[31], first_x} - {second_x[31], second_x};
            d_reg[1] <= {first_y[31], first_y} - {second_y[31], second_y};
            d_reg[2] <= {first_z[31], first_z} - {second_z[31], second_z};
        end
    end

    // Stage 2: squares of the difference, and direction scaled to put the largest in [2^30, 2^31).
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dmag[i] = d_reg[i][32] ? 32'(-d_reg[i]) : d_reg[i][31:0];
        end
        mx = dmag[0];
        if (dmag[1] > mx) mx = dmag[1];
        if (dmag[2] > mx) mx = dmag[2];
        mxs = mx[30:0];
        for (int i = 0; i < 3; i++)
        begin
            sm[i] = dmag[i][30:0];
        end
        if (mx[31])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sm[i] = dmag[i][31:1];
            end
        end
        else
        begin
            for (int j = 4; j >= 0; j--)
            begin
                if ((mxs >> (31 - (1 << j))) == '0)
                begin
                    mxs = mxs << (1 << j);
                    for (int i = 0; i < 3; i++)
                    begin
                        sm[i] = sm[i] << (1 << j);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dsq_reg[i] <= {32'd0, dmag[i]} * {32'd0, dmag[i]};
                s_reg[i]   <= d_reg[i][32] ? -{1'b0, sm[i]} : {1'b0, sm[i]};
            end
        end
    end

    // Stage 3: squared center distance and the raw tangent.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dsum_reg <= 66'(dsq_reg[0]) + 66'(dsq_reg[1]) + 66'(dsq_reg[2]);
            t_reg[0] <= {s_reg[1][31], s_reg[1]} - {s_reg[2][31], s_reg[2]};
            t_reg[1] <= 33'd0 - ({s_reg[0][31], s_reg[0]} + {s_reg[2][31], s_reg[2]});
            t_reg[2] <= {s_reg[0][31], s_reg[0]} + {s_reg[1][31], s_reg[1]};
            s3_reg   <= s_reg;
        end
    end

    // Stage 4: squares of the scaled direction and the tangent.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s3mag[i] = s3_reg[i][31] ? 31'(-s3_reg[i]) : s3_reg[i][30:0];
            t3mag[i] = t_reg[i][32] ? 32'(-t_reg[i]) : t_reg[i][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ssq_reg[i] <= {31'd0, s3mag[i]} * {31'd0, s3mag[i]};
                tsq_reg[i] <= {32'd0, t3mag[i]} * {32'd0, t3mag[i]};
            end
            s_pipe[0]  <= s3_reg;
            t_pipe[0]  <= t_reg;
            zf_pipe[0] <= (t_reg[0] == '0) && (t_reg[1] == '0) && (t_reg[2] == '0);
            for (int k = 1; k < ST_DLY; k++)
            begin
                s_pipe[k] <= s_pipe[k-1];
                t_pipe[k] <= t_pipe[k-1];
            end
            for (int k = 1; k < ZF_DLY; k++)
            begin
                zf_pipe[k] <= zf_pipe[k-1];
            end
        end
    end

    // Stage 5: squared norms of the scaled direction and the tangent.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ssum_reg <= 64'(ssq_reg[0]) + 64'(ssq_reg[1]) + 64'(ssq_reg[2]);
            tsum_reg <= 66'(tsq_reg[0]) + 66'(tsq_reg[1]) + 66'(tsq_reg[2]);
        end
    end

    // Square root rows.
    scf_root u_root_d (
        .clk      (clk),
        .ena      (adv),
        .radicand (dsum_reg),
        .root     (dnorm)
    );

    scf_root u_root_s (
        .clk      (clk),
        .ena      (adv),
        .radicand (66'(ssum_reg)),
        .root     (snorm)
    );

    scf_root u_root_t (
        .clk      (clk),
        .ena      (adv),
        .radicand (tsum_reg),
        .root     (tnorm)
    );

    // Gap: distance minus both radii, saturated, then carried to the output.
    always_comb
    begin
        gap_wide = $signed({2'b00, dnorm}) - $signed({4'b0000, radius_one_reg})
                 - $signed({4'b0000, radius_two_reg});
        if (gap_wide[34:31] == 4'b0000 || gap_wide[34:31] == 4'b1111)
        begin
            gap_sat = gap_wide[31:0];
        end
        else if (gap_wide[34])
        begin
            gap_sat = 32'sh8000_0000;
        end
        else
        begin
            gap_sat = 32'sh7fff_ffff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gap_pipe[0] <= gap_sat;
            for (int k = 1; k < GP_DLY; k++)
            begin
                gap_pipe[k] <= gap_pipe[k-1];
            end
        end
    end

    // Divider inputs: magnitude times 2^30 plus half the norm, for rounding to nearest.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            snum[i]  = s_pipe[ST_DLY-1][i][31] ? 32'(-s_pipe[ST_DLY-1][i])
                                               : 32'(s_pipe[ST_DLY-1][i]);
            tnum[i]  = t_pipe[ST_DLY-1][i][32] ? 32'(-t_pipe[ST_DLY-1][i])
                                               : t_pipe[ST_DLY-1][i][31:0];
            n_dvd[i] = {1'b0, snum[i], scf_pkg::FRAC_W'(0)}
                     + scf_pkg::DVD_W'(snorm >> 1);
            u_dvd[i] = {1'b0, tnum[i], scf_pkg::FRAC_W'(0)}
                     + scf_pkg::DVD_W'(tnorm >> 1);
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_unit
        scf_div u_div_n (
            .clk      (clk),
            .ena      (adv),
            .dividend (n_dvd[g]),
            .den      (snorm),
            .quo      (n_quo[g])
        );

        scf_div u_div_u (
            .clk      (clk),
            .ena      (adv),
            .dividend (u_dvd[g]),
            .den      (tnorm),
            .quo      (u_quo[g])
        );
    end

    // Signs travel beside the dividers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sg_pipe[0] <= {t_pipe[ST_DLY-1][2][32], t_pipe[ST_DLY-1][1][32],
                           t_pipe[ST_DLY-1][0][32], s_pipe[ST_DLY-1][2][31],
                           s_pipe[ST_DLY-1][1][31], s_pipe[ST_DLY-1][0][31]};
            for (int k = 1; k < SG_DLY; k++)
            begin
                sg_pipe[k] <= sg_pipe[k-1];
            end
        end
    end

    // Signed unit vectors, zeroed for a degenerate pair, then carried to the output.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (zf_pipe[ZF_DLY-5])
                begin
                    n_pipe[0][i] <= '0;
                    u_pipe[0][i] <= '0;
                end
                else
                begin
                    n_pipe[0][i] <= sg_pipe[SG_DLY-1][i] ? -{1'b0, n_quo[i]} : {1'b0, n_quo[i]};
                    u_pipe[0][i] <= sg_pipe[SG_DLY-1][i+3] ? -{1'b0, u_quo[i]}
                                                           : {1'b0, u_quo[i]};
                end
            end
            for (int k = 1; k < NU_DLY; k++)
            begin
                n_pipe[k] <= n_pipe[k-1];
                u_pipe[k] <= u_pipe[k-1];
            end
        end
    end

    // Second tangent: cross product n x u, one multiply stage then one subtract stage.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg[0] <= n_pipe[0][1] * u_pipe[0][2];
            prod_reg[1] <= n_pipe[0][2] * u_pipe[0][1];
            prod_reg[2] <= n_pipe[0][2] * u_pipe[0][0];
            prod_reg[3] <= n_pipe[0][0] * u_pipe[0][2];
            prod_reg[4] <= n_pipe[0][0] * u_pipe[0][1];
            prod_reg[5] <= n_pipe[0][1] * u_pipe[0][0];
            for (int i = 0; i < 3; i++)
            begin
                cross_reg[i] <= {prod_reg[2*i][63], prod_reg[2*i]}
                              - {prod_reg[2*i+1][63], prod_reg[2*i+1]};
            end
        end
    end

    // Drop 30 fraction bits, rounding halves away from zero.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cmag[i] = cross_reg[i][64] ? 65'(-cross_reg[i]) : 65'(cross_reg[i]);
            crnd[i] = (cmag[i] + (65'd1 << (scf_pkg::FRAC_W - 1))) >> scf_pkg::FRAC_W;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                v_reg[i] <= cross_reg[i][64] ? -crnd[i][31:0] : crnd[i][31:0];
            end
        end
    end

    // Output register view.
    assign result_valid = vld_reg[LAT];
    assign gap          = gap_pipe[GP_DLY-1];
    assign normal_x     = n_pipe[NU_DLY-1][0];
    assign normal_y     = n_pipe[NU_DLY-1][1];
    assign normal_z     = n_pipe[NU_DLY-1][2];
    assign tangent_u_x  = u_pipe[NU_DLY-1][0];
    assign tangent_u_y  = u_pipe[NU_DLY-1][1];
    assign tangent_u_z  = u_pipe[NU_DLY-1][2];
    assign tangent_v_x  = v_reg[0];
    assign tangent_v_y  = v_reg[1];
    assign tangent_v_z  = v_reg[2];
    assign degenerate   = zf_pipe[ZF_DLY-1];

endmodule

/* src/scf_checker.sv */
// Port-level checks on the sphere contact frame, bound to the top level.
`timescale 1ns / 1ps

module scf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_stall,
    input logic               result_valid,
    input logic               result_stall,
    input logic signed [31:0] gap,
    input logic signed [31:0] normal_x,
    input logic signed [31:0] normal_y,
    input logic signed [31:0] normal_z,
    input logic signed [31:0] tangent_u_x,
    input logic signed [31:0] tangent_u_y,
    input logic signed [31:0] tangent_u_z,
    input logic signed [31:0] tangent_v_x,
    input logic signed [31:0] tangent_v_y,
    input logic signed [31:0] tangent_v_z,
    input logic               degenerate
);

    // The input side stalls exactly when a result is held at the output.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall == (result_valid && result_stall))
        else $error("item_stall does not follow the held result");

    // A degenerate pair carries an all-zero frame.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && degenerate |->
            normal_x == 0 && normal_y == 0 && normal_z == 0 &&
            tangent_u_x == 0 && tangent_u_y == 0 && tangent_u_z == 0 &&
            tangent_v_x == 0 && tangent_v_y == 0 && tangent_v_z == 0)
        else $error("degenerate item with a nonzero frame");

    // A proper frame has a nonzero normal.
    a_normal_set: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !degenerate |-> normal_x != 0 || normal_y != 0 || normal_z != 0)
        else $error("nondegenerate item with a zero normal");

    // A held result keeps result_valid, gap and degenerate in place.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(gap) && $stable(degenerate))
        else $error("held result changed");

endmodule

bind sphere_contact_frame scf_checker u_scf_checker (.*);
